// ===== design/acdc_pkg.sv =====
// ----------------------------------------------------------------------------
// acdc_pkg: shared types and constants for the ARGB channel depth converter
// Pixel structs, depth codes and the configuration map.
// ----------------------------------------------------------------------------
package acdc_pkg;

	// Channel depth codes
	localparam logic [1:0] FMT_4  = 2'd0;
	localparam logic [1:0] FMT_8  = 2'd1;
	localparam logic [1:0] FMT_16 = 2'd2;
	// Spare code, behaves as 16-bit
	localparam logic [1:0] FMT_SAT = 2'd3;

	// Number of channels per pixel
	localparam int NUM_CH = 4;

	// Configuration register indexes (byte address / 4)
	localparam logic REG_SRC_FORMAT = 1'b0;
	localparam logic REG_DST_FORMAT = 1'b1;

	// Reset value of both format registers
	localparam logic [1:0] FMT_RESET = FMT_8;

	typedef struct packed {
		logic [15:0] alpha_in;
		logic [15:0] red_in;
		logic [15:0] green_in;
		logic [15:0] blue_in;
		logic        last_pixel;
	} acdc_pixel_in_t;

	typedef struct packed {
		logic [15:0] alpha_out;
		logic [15:0] red_out;
		logic [15:0] green_out;
		logic [15:0] blue_out;
		logic        last_out;
	} acdc_pixel_out_t;

	// Resolved source and destination depths handed to every lane
	typedef struct packed {
		logic [1:0] src;
		logic [1:0] dst;
	} acdc_fmt_t;

	// Code three saturates to the 16-bit depth
	function automatic logic [1:0] depth_code(input logic [1:0] code);
		depth_code = (code == FMT_SAT) ? FMT_16 : code;
	endfunction

endpackage

// ===== design/acdc_lane.sv =====
// ----------------------------------------------------------------------------
// acdc_lane: one channel depth converter
// Widens by bit replication, narrows with round-to-nearest using a
// shift-add division by 2^k-1.
// ----------------------------------------------------------------------------
module acdc_lane (
	input  acdc_pkg::acdc_fmt_t fmt,
	input  logic [15:0]         chan_in,
	output logic [15:0]         chan_out
);

	logic [3:0]  v4;
	logic [7:0]  v8;
	logic [15:0] v16;

	// 8 -> 4: (v*15 + 127) / 255
	logic [11:0] n84_x;
	logic [11:0] n84_sum;
	// 16 -> 4: (v*15 + 32767) / 65535
	logic [19:0] n164_x;
	logic [19:0] n164_sum;
	// 16 -> 8: (v*255 + 32767) / 65535
	logic [23:0] n168_x;
	logic [23:0] n168_sum;

	assign v4  = chan_in[3:0];
	assign v8  = chan_in[7:0];
	assign v16 = chan_in;

	// x / (2^k - 1) == (x + 1 + (x >> k)) >> k while the quotient stays below 2^k
	always_comb begin
		n84_x    = {v8, 4'b0000} - {4'b0000, v8} + 12'd127;
		n84_sum  = n84_x + 12'd1 + {8'd0, n84_x[11:8]};
		n164_x   = {v16, 4'b0000} - {4'd0, v16} + 20'd32767;
		n164_sum = n164_x + 20'd1 + {16'd0, n164_x[19:16]};
		n168_x   = {v16, 8'd0} - {8'd0, v16} + 24'd32767;
		n168_sum = n168_x + 24'd1 + {16'd0, n168_x[23:16]};
	end

	// Select the conversion for the current format pair
	always_comb begin
		case ({fmt.src, fmt.dst})
			{acdc_pkg::FMT_4, acdc_pkg::FMT_4}:   chan_out = {12'd0, v4};
			{acdc_pkg::FMT_4, acdc_pkg::FMT_8}:   chan_out = {8'd0, v4, v4};
			{acdc_pkg::FMT_4, acdc_pkg::FMT_16}:  chan_out = {v4, v4, v4, v4};
			{acdc_pkg::FMT_8, acdc_pkg::FMT_4}:   chan_out = {12'd0, n84_sum[11:8]};
			{acdc_pkg::FMT_8, acdc_pkg::FMT_8}:   chan_out = {8'd0, v8};
			{acdc_pkg::FMT_8, acdc_pkg::FMT_16}:  chan_out = {v8, v8};
			{acdc_pkg::FMT_16, acdc_pkg::FMT_4}:  chan_out = {12'd0, n164_sum[19:16]};
			{acdc_pkg::FMT_16, acdc_pkg::FMT_8}:  chan_out = {8'd0, n168_sum[23:16]};
			{acdc_pkg::FMT_16, acdc_pkg::FMT_16}: chan_out = v16;
			default:                              chan_out = v16;
		endcase
	end

endmodule

// ===== design/acdc_out_buf.sv =====
// ----------------------------------------------------------------------------
// acdc_out_buf: merge and output stage
// Packs the lane results with the last mark into one item and holds it in a
// two-entry skid buffer so input ready never waits on output ready.
// ----------------------------------------------------------------------------
module acdc_out_buf (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_fire,
	input  logic [15:0]               lane_res [acdc_pkg::NUM_CH],
	input  logic                      last_pixel,
	output logic                      buf_ready,
	output logic                      out_valid,
	input  logic                      out_ready,
	output acdc_pkg::acdc_pixel_out_t out_data
);

	acdc_pkg::acdc_pixel_out_t merged;
	acdc_pkg::acdc_pixel_out_t main_q;
	acdc_pkg::acdc_pixel_out_t skid_q;
	logic                      main_valid_q;
	logic                      skid_valid_q;
	logic                      out_fire;

	// Merge lanes into one result item
	always_comb begin
		merged.alpha_out = lane_res[0];
		merged.red_out   = lane_res[1];
		merged.green_out = lane_res[2];
		merged.blue_out  = lane_res[3];
		merged.last_out  = last_pixel;
	end

	assign out_fire  = main_valid_q && out_ready;
	assign buf_ready = !skid_valid_q;
	assign out_valid = main_valid_q;
	assign out_data  = main_q;

	// Occupancy flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			main_valid_q <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (out_fire) begin
			if (skid_valid_q) begin
				skid_valid_q <= 1'b0;
			end else begin
				main_valid_q <= in_fire;
			end
		end else if (in_fire) begin
			if (main_valid_q) begin
				skid_valid_q <= 1'b1;
			end else begin
				main_valid_q <= 1'b1;
			end
		end
	end

	// Payload, no reset needed
	always_ff @(posedge clk) begin
		if (out_fire) begin
			if (skid_valid_q) begin
				main_q <= skid_q;
			end else if (in_fire) begin
				main_q <= merged;
			end
		end else if (in_fire) begin
			if (main_valid_q) begin
				skid_q <= merged;
			end else begin
				main_q <= merged;
			end
		end
	end

endmodule

// ===== design/argb_channel_depth_converter_core.sv =====
// ----------------------------------------------------------------------------
// argb_channel_depth_converter_core: ARGB pixel channel depth converter
// Converts each pixel between 4-, 8- and 16-bit channels, set over APB.
// ----------------------------------------------------------------------------
// Takes one pixel per clock while in_ready is high and returns it from the
// output register; four combinational channel lanes convert alpha, red,
// green and blue in parallel. A two-entry output buffer lets one more pixel in
// while a result is stalled, so in_ready drops only when both entries are
// full. src_format sits at address 0x0 and dst_format at 0x4 (0 = 4-bit,
// 1 = 8-bit, 2 = 16-bit, 3 acts as 16-bit); both reset to 8-bit. Change them
// only while no pixel is in flight. Results sit in the low bits of each
// channel with zeros above.
module argb_channel_depth_converter_core (
	input  logic                      clk,
	input  logic                      arst_n,
	// APB configuration
	input  logic                      psel,
	input  logic                      penable,
	input  logic                      pwrite,
	input  logic [2:0]                paddr,
	input  logic [31:0]               pwdata,
	output logic [31:0]               prdata,
	output logic                      pready,
	// Pixel input
	input  logic                      in_valid,
	output logic                      in_ready,
	input  acdc_pkg::acdc_pixel_in_t  in_data,
	// Pixel output
	output logic                      out_valid,
	input  logic                      out_ready,
	output acdc_pkg::acdc_pixel_out_t out_data
);

	logic [1:0]          src_format_q;
	logic [1:0]          dst_format_q;
	logic                cfg_wr;
	logic                in_fire;
	acdc_pkg::acdc_fmt_t fmt;
	logic [15:0]         lane_in  [acdc_pkg::NUM_CH];
	logic [15:0]         lane_res [acdc_pkg::NUM_CH];

	// Configuration registers
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			src_format_q <= acdc_pkg::FMT_RESET;
			dst_format_q <= acdc_pkg::FMT_RESET;
		end else if (cfg_wr) begin
			if (paddr[2] == acdc_pkg::REG_SRC_FORMAT) begin
				src_format_q <= pwdata[1:0];
			end else begin
				dst_format_q <= pwdata[1:0];
			end
		end
	end

	// Register readback
	always_comb begin
		if (paddr[2] == acdc_pkg::REG_SRC_FORMAT) begin
			prdata = {30'd0, src_format_q};
		end else begin
			prdata = {30'd0, dst_format_q};
		end
	end

	assign fmt.src = acdc_pkg::depth_code(src_format_q);
	assign fmt.dst = acdc_pkg::depth_code(dst_format_q);

	assign in_fire = in_valid && in_ready;

	// Channel lanes
	assign lane_in[0] = in_data.alpha_in;
	assign lane_in[1] = in_data.red_in;
	assign lane_in[2] = in_data.green_in;
	assign lane_in[3] = in_data.blue_in;

	for (genvar i = 0; i < acdc_pkg::NUM_CH; i++) begin : g_lane
		acdc_lane u_lane (
			.fmt      (fmt),
			.chan_in  (lane_in[i]),
			.chan_out (lane_res[i])
		);
	end

	// Merge and output buffer
	acdc_out_buf u_out_buf (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_fire    (in_fire),
		.lane_res   (lane_res),
		.last_pixel (in_data.last_pixel),
		.buf_ready  (in_ready),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.out_data   (out_data)
	);

endmodule

// ===== design/acdc_checker.sv =====
// ----------------------------------------------------------------------------
// acdc_checker: port-level checks for the depth converter
// Latency, backpressure and output hold rules, bound to the top level.
// ----------------------------------------------------------------------------
module acdc_checker (
	input logic                      clk,
	input logic                      arst_n,
	input logic                      in_valid,
	input logic                      in_ready,
	input logic                      out_valid,
	input logic                      out_ready,
	input acdc_pkg::acdc_pixel_out_t out_data
);

	// A stalled result item holds its value
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("output item changed while stalled");

	// An item accepted into an empty output shows up in the next cycle
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && !out_valid |=> out_valid)
		else $error("accepted item did not reach the output");

	// Input backpressure only while a result is pending
	a_backpressure: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> out_valid)
		else $error("input stalled with empty output");

	// A full buffer frees its slot once the output drains
	a_drain: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready && out_ready |=> in_ready)
		else $error("input stayed stalled after output accepted");

endmodule

bind argb_channel_depth_converter_core acdc_checker u_acdc_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_ready  (in_ready),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.out_data  (out_data)
);
